// ===== hdl/rrs_pkg.sv =====
// ============================================================================
// rrs_pkg
// Shared widths, constants, control word types and the microcode table
// for the round-robin schedule unit.
// ============================================================================
package rrs_pkg;

    // Field widths
    localparam int DATA_W   = 16;
    localparam int Q_W      = 8;
    localparam int TIME_W   = 23;
    localparam int SUM_W    = 29;
    localparam int IDX_W    = 6;

    // Defaults
    localparam int             MAX_PROC_DEF  = 64;
    localparam logic [Q_W-1:0] QUANTUM_RESET = 8'd10;

    // Memory read select
    typedef enum logic [1:0] {
        RD_NONE,
        RD_VISIT,
        RD_NEXT
    } t_rd;

    // Datapath operation
    typedef enum logic [2:0] {
        OP_NONE,
        OP_JUMP,
        OP_SERVE,
        OP_TA,
        OP_WT,
        OP_EMIT,
        OP_SCAN
    } t_op;

    // Jump condition
    typedef enum logic [2:0] {
        JC_STEP,
        JC_START,
        JC_DONE,
        JC_MORE,
        JC_HOLD,
        JC_LEFT
    } t_jc;

    // Program steps
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_JUMP,
        ST_SERVE,
        ST_TA,
        ST_WT,
        ST_EMIT,
        ST_NEXT,
        ST_SCAN
    } t_step;

    // One control word
    typedef struct packed {
        logic  accept;
        t_rd   rd;
        t_op   op;
        t_jc   jc;
        t_step target;
    } t_uop;

    // Status flags from datapath to sequencer
    typedef struct packed {
        logic start;   // last item taken, begin simulation
        logic done;    // visited process already complete
        logic more;    // remaining work exceeds the quantum
        logic busy;    // output word still waiting
        logic left;    // unfinished processes remain
    } t_cond;

    // Microcode ROM
    function automatic t_uop f_ucode(input t_step s);
        t_uop u;
        u = '{accept: 1'b0, rd: RD_NONE, op: OP_NONE, jc: JC_STEP, target: ST_IDLE};
        unique case (s)
            ST_IDLE:  u = '{1'b1, RD_NONE,  OP_NONE,  JC_START, ST_FETCH};
            ST_FETCH: u = '{1'b0, RD_VISIT, OP_NONE,  JC_STEP,  ST_IDLE};
            ST_JUMP:  u = '{1'b0, RD_NONE,  OP_JUMP,  JC_DONE,  ST_NEXT};
            ST_SERVE: u = '{1'b0, RD_NONE,  OP_SERVE, JC_MORE,  ST_NEXT};
            ST_TA:    u = '{1'b0, RD_NONE,  OP_TA,    JC_STEP,  ST_IDLE};
            ST_WT:    u = '{1'b0, RD_NONE,  OP_WT,    JC_STEP,  ST_IDLE};
            ST_EMIT:  u = '{1'b0, RD_NONE,  OP_EMIT,  JC_HOLD,  ST_IDLE};
            ST_NEXT:  u = '{1'b0, RD_NEXT,  OP_NONE,  JC_STEP,  ST_IDLE};
            ST_SCAN:  u = '{1'b0, RD_NONE,  OP_SCAN,  JC_LEFT,  ST_FETCH};
            default:  u = '{1'b1, RD_NONE,  OP_NONE,  JC_START, ST_FETCH};
        endcase
        return u;
    endfunction

endpackage

// ===== hdl/rrs_seq.sv =====
// ============================================================================
// rrs_seq
// Step counter and microcode ROM; resolves conditional jumps from the
// datapath flags.
// ============================================================================
module rrs_seq
    import rrs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cond i_cond,
    output t_uop  o_uop
);

    t_step r_step;
    t_step n_step;
    t_step step_inc;
    t_uop  uop;

    assign uop      = f_ucode(r_step);
    assign o_uop    = uop;
    assign step_inc = t_step'(r_step + 4'd1);

    // Next step select
    always_comb begin
        n_step = step_inc;
        unique case (uop.jc)
            JC_STEP:  n_step = step_inc;
            JC_START: n_step = i_cond.start ? uop.target : r_step;
            JC_DONE:  n_step = i_cond.done  ? uop.target : step_inc;
            JC_MORE:  n_step = i_cond.more  ? uop.target : step_inc;
            JC_HOLD:  n_step = i_cond.busy  ? r_step     : step_inc;
            JC_LEFT:  n_step = i_cond.left  ? uop.target : ST_IDLE;
            default:  n_step = ST_IDLE;
        endcase
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== hdl/rrs_datapath.sv =====
// ============================================================================
// rrs_datapath
// Process stores, time and sum registers, done bits and the output word
// register, driven by the control word.
// ============================================================================
module rrs_datapath
    import rrs_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROC_DEF
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_uop              i_uop,
    output t_cond             o_cond,
    input  logic [Q_W-1:0]    i_quantum,
    input  logic              i_in_valid,
    input  logic [DATA_W-1:0] i_arrival_time,
    input  logic [DATA_W-1:0] i_burst_time,
    input  logic              i_last_process,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [IDX_W-1:0]  o_process_index,
    output logic [TIME_W-1:0] o_turnaround,
    output logic [TIME_W-1:0] o_waiting,
    output logic [SUM_W-1:0]  o_total_waiting,
    output logic [SUM_W-1:0]  o_total_turnaround,
    output logic              o_last_result
);

    localparam int IW = $clog2(MAX_PROCESSES);
    localparam int CW = $clog2(MAX_PROCESSES + 1);

    // Stores
    logic [DATA_W-1:0] r_arr_mem [MAX_PROCESSES];
    logic [DATA_W-1:0] r_bur_mem [MAX_PROCESSES];
    logic [DATA_W-1:0] r_rem_mem [MAX_PROCESSES];

    // Batch and control state
    logic [MAX_PROCESSES-1:0] r_done;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_unfin;
    logic [IW-1:0]            r_idx;
    logic [TIME_W-1:0]        r_time;
    logic [SUM_W-1:0]         r_sum_w;
    logic [SUM_W-1:0]         r_sum_t;
    logic                     r_out_valid;

    // Payload registers
    logic [DATA_W-1:0] r_prev_arr;
    logic [DATA_W-1:0] r_arr_q;
    logic [DATA_W-1:0] r_bur_q;
    logic [DATA_W-1:0] r_rem_q;
    logic [TIME_W-1:0] r_ta;
    logic [TIME_W-1:0] r_wt;
    logic [IW-1:0]     r_out_idx;
    logic [TIME_W-1:0] r_out_ta;
    logic [TIME_W-1:0] r_out_wt;
    logic [SUM_W-1:0]  r_out_sum_w;
    logic [SUM_W-1:0]  r_out_sum_t;
    logic              r_out_last;

    logic              ld_fire;
    logic              ld_wr;
    logic [DATA_W-1:0] ld_arr;
    logic [IW-1:0]     first_open;
    logic [IW-1:0]     rd_addr;
    logic              out_busy;
    logic              emit_fire;
    logic              more;
    logic [CW-1:0]     nxt_idx;
    logic [SUM_W-1:0]  sum_w_new;
    logic [TIME_W-1:0] arr_ext;

    // Load side: one process per accepted word while the table has room
    assign ld_fire = i_in_valid && i_uop.accept;
    assign ld_wr   = ld_fire && (r_count < CW'(MAX_PROCESSES));
    assign ld_arr  = (r_count != '0 && i_arrival_time < r_prev_arr) ? r_prev_arr
                                                                      : i_arrival_time;

    // Lowest unfinished entry; stored arrivals are nondecreasing, so its
    // arrival is the earliest among unfinished processes
    always_comb begin
        first_open = '0;
        for (int k = MAX_PROCESSES - 1; k >= 0; k--) begin
            if (!r_done[k]) begin
                first_open = IW'(k);
            end
        end
    end

    // Read address
    always_comb begin
        if (i_uop.rd == RD_NEXT) begin
            rd_addr = IW'(r_idx + IW'(1));
        end else if (r_idx == '0) begin
            rd_addr = first_open;
        end else begin
            rd_addr = r_idx;
        end
    end

    assign arr_ext   = TIME_W'(r_arr_q);
    assign more      = r_rem_q > DATA_W'(i_quantum);
    assign out_busy  = r_out_valid && i_out_stall;
    assign emit_fire = (i_uop.op == OP_EMIT) && !out_busy;
    assign nxt_idx   = CW'(r_idx) + CW'(1);
    assign sum_w_new = r_sum_w + SUM_W'(r_wt);

    // Flags to sequencer
    assign o_cond.start = ld_fire && i_last_process;
    assign o_cond.done  = r_done[r_idx];
    assign o_cond.more  = more;
    assign o_cond.busy  = out_busy;
    assign o_cond.left  = r_unfin != '0;

    // Memories
    always_ff @(posedge i_clk) begin
        if (ld_wr) begin
            r_arr_mem[r_count[IW-1:0]] <= ld_arr;
            r_bur_mem[r_count[IW-1:0]] <= i_burst_time;
        end
        if (ld_wr) begin
            r_rem_mem[r_count[IW-1:0]] <= i_burst_time;
        end else if (i_uop.op == OP_SERVE) begin
            r_rem_mem[r_idx] <= more ? DATA_W'(r_rem_q - DATA_W'(i_quantum)) : '0;
        end
        if (i_uop.rd != RD_NONE) begin
            r_arr_q <= r_arr_mem[rd_addr];
        end
        if (i_uop.rd == RD_VISIT) begin
            r_bur_q <= r_bur_mem[r_idx];
            r_rem_q <= r_rem_mem[r_idx];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (ld_wr) begin
            r_prev_arr <= ld_arr;
        end
        if (i_uop.op == OP_TA) begin
            r_ta <= r_time - arr_ext;
        end
        if (i_uop.op == OP_WT) begin
            r_wt <= r_ta - TIME_W'(r_bur_q);
        end
        if (emit_fire) begin
            r_out_idx   <= r_idx;
            r_out_ta    <= r_ta;
            r_out_wt    <= r_wt;
            r_out_sum_w <= sum_w_new;
            r_out_sum_t <= r_sum_t;
            r_out_last  <= r_unfin == '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '1;
            r_count     <= '0;
            r_unfin     <= '0;
            r_idx       <= '0;
            r_time      <= '0;
            r_sum_w     <= '0;
            r_sum_t     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output word handshake
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (ld_wr) begin
                r_done[r_count[IW-1:0]] <= 1'b0;
                r_count <= r_count + CW'(1);
                r_unfin <= r_unfin + CW'(1);
            end

            case (i_uop.op)
                OP_JUMP: begin
                    // nothing ready, or visited before its arrival
                    if ((r_idx == '0 || !r_done[r_idx]) && arr_ext > r_time) begin
                        r_time <= arr_ext;
                    end
                end
                OP_SERVE: begin
                    if (more) begin
                        r_time <= r_time + TIME_W'(i_quantum);
                    end else begin
                        r_time          <= r_time + TIME_W'(r_rem_q);
                        r_done[r_idx]   <= 1'b1;
                        r_unfin         <= r_unfin - CW'(1);
                    end
                end
                OP_WT: begin
                    r_sum_t <= r_sum_t + SUM_W'(r_ta);
                end
                OP_EMIT: begin
                    if (!out_busy) begin
                        r_sum_w <= sum_w_new;
                    end
                end
                OP_SCAN: begin
                    if (r_unfin == '0) begin
                        // batch finished: clear for the next one
                        r_done  <= '1;
                        r_count <= '0;
                        r_idx   <= '0;
                        r_time  <= '0;
                        r_sum_w <= '0;
                        r_sum_t <= '0;
                    end else if (nxt_idx >= r_count) begin
                        r_idx <= '0;
                    end else if (arr_ext <= r_time) begin
                        r_idx <= nxt_idx[IW-1:0];
                    end else begin
                        r_idx <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Outputs
    assign o_out_valid        = r_out_valid;
    assign o_process_index    = IDX_W'(r_out_idx);
    assign o_turnaround       = r_out_ta;
    assign o_waiting          = r_out_wt;
    assign o_total_waiting    = r_out_sum_w;
    assign o_total_turnaround = r_out_sum_t;
    assign o_last_result      = r_out_last;

endmodule

// ===== hdl/round_robin_schedule_sim_unit.sv =====
// Loading: one process word per cycle while idle; the word with last_process
// set starts the simulation and the input stalls until it ends.
// Simulation: a visit runs the microcode steps fetch, jump, next and scan
// (already finished), adds serve (partial service), or serve, ta, wt and emit,
// emit held while the output stalls (completion); store reads are single-port.
// Reset: synchronous, active low; quantum returns to 10 and the batch is empty.
// ============================================================================
// round_robin_schedule_sim_unit
// Round-robin scheduling simulator: loads processes, then replays
// round-robin service and reports turnaround and waiting per completion.
// ============================================================================
module round_robin_schedule_sim_unit
    import rrs_pkg::*;
#(
    parameter int MAX_PROCESSES = MAX_PROC_DEF
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [Q_W-1:0]    i_cfg_quantum,
    // process words
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [DATA_W-1:0] i_arrival_time,
    input  logic [DATA_W-1:0] i_burst_time,
    input  logic              i_last_process,
    // result words
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [IDX_W-1:0]  o_process_index,
    output logic [TIME_W-1:0] o_turnaround,
    output logic [TIME_W-1:0] o_waiting,
    output logic [SUM_W-1:0]  o_total_waiting,
    output logic [SUM_W-1:0]  o_total_turnaround,
    output logic              o_last_result
);

    logic [Q_W-1:0] r_quantum;
    logic [Q_W-1:0] q_eff;
    t_uop           uop;
    t_cond          cond;

    // Quantum register; zero acts as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= QUANTUM_RESET;
        end else if (i_cfg_valid) begin
            r_quantum <= i_cfg_quantum;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign q_eff       = (r_quantum == '0) ? Q_W'(1) : r_quantum;
    assign o_in_stall  = !uop.accept;

    rrs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_uop   (uop)
    );

    rrs_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_uop              (uop),
        .o_cond             (cond),
        .i_quantum          (q_eff),
        .i_in_valid         (i_in_valid),
        .i_arrival_time     (i_arrival_time),
        .i_burst_time       (i_burst_time),
        .i_last_process     (i_last_process),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_process_index    (o_process_index),
        .o_turnaround       (o_turnaround),
        .o_waiting          (o_waiting),
        .o_total_waiting    (o_total_waiting),
        .o_total_turnaround (o_total_turnaround),
        .o_last_result      (o_last_result)
    );

endmodule

// ===== tb/rrs_schedule_monitor.sv =====
// ============================================================================
// rrs_schedule_monitor
// Watches the configuration, process and result channels of the round-robin
// schedule unit. Keeps its own copy of the quantum and the process table,
// replays the schedule when the final process word is taken, and compares
// every result word field by field against the oldest predicted completion.
// ============================================================================
module rrs_schedule_monitor
    import rrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [Q_W-1:0]    i_cfg_quantum,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [DATA_W-1:0] i_arrival_time,
    input  logic [DATA_W-1:0] i_burst_time,
    input  logic              i_last_process,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [IDX_W-1:0]  i_process_index,
    input  logic [TIME_W-1:0] i_turnaround,
    input  logic [TIME_W-1:0] i_waiting,
    input  logic [SUM_W-1:0]  i_total_waiting,
    input  logic [SUM_W-1:0]  i_total_turnaround,
    input  logic              i_last_result,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int TABLE_DEPTH = MAX_PROC_DEF;

    // One predicted completion
    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [SUM_W-1:0]  total_waiting;
        logic [SUM_W-1:0]  total_turnaround;
        logic              last;
    } t_completion;

    // Local copy of the block state
    logic [Q_W-1:0]    quantum;
    logic [DATA_W-1:0] arrival_tbl   [TABLE_DEPTH];
    logic [DATA_W-1:0] burst_tbl     [TABLE_DEPTH];
    logic [DATA_W-1:0] remaining_tbl [TABLE_DEPTH];
    logic              finished      [TABLE_DEPTH];
    int unsigned       proc_count;
    int unsigned       open_count;

    t_completion completion_q [$];
    int          mismatch_count = 0;
    int          pending_count  = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending_count;

    // Replay round-robin service over the loaded table
    task automatic replay_schedule();
        int unsigned       slot;
        int unsigned       scan;
        int unsigned       k;
        int unsigned       earliest;
        int unsigned       rem;
        int unsigned       slice;
        logic              ready;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] ta;
        logic [TIME_W-1:0] wt;
        logic [SUM_W-1:0]  sum_wt;
        logic [SUM_W-1:0]  sum_ta;
        t_completion       c;
        slice  = (quantum == '0) ? 1 : quantum;
        scan   = 0;
        now    = '0;
        sum_wt = '0;
        sum_ta = '0;
        while (open_count > 0) begin
            slot = scan % TABLE_DEPTH;
            // at the head of the table, jump ahead when nothing has arrived
            if (slot == 0) begin
                ready    = 1'b0;
                earliest = 32'hFFFF_FFFF;
                for (k = 0; k < proc_count; k++) begin
                    if (!finished[k]) begin
                        if (arrival_tbl[k] <= now) ready = 1'b1;
                        if (arrival_tbl[k] < earliest) earliest = arrival_tbl[k];
                    end
                end
                if (!ready) now = TIME_W'(earliest);
            end
            if (!finished[slot]) begin
                rem = remaining_tbl[slot];
                if (arrival_tbl[slot] > now) now = TIME_W'(arrival_tbl[slot]);
                if (rem <= slice) begin
                    now                 = now + TIME_W'(rem);
                    remaining_tbl[slot] = '0;
                    finished[slot]      = 1'b1;
                    open_count--;
                    ta     = now - TIME_W'(arrival_tbl[slot]);
                    wt     = ta - TIME_W'(burst_tbl[slot]);
                    sum_wt = sum_wt + SUM_W'(wt);
                    sum_ta = sum_ta + SUM_W'(ta);
                    c.index            = IDX_W'(slot);
                    c.turnaround       = ta;
                    c.waiting          = wt;
                    c.total_waiting    = sum_wt;
                    c.total_turnaround = sum_ta;
                    c.last             = (open_count == 0);
                    completion_q.push_back(c);
                end else begin
                    remaining_tbl[slot] = DATA_W'(rem - slice);
                    now                 = now + TIME_W'(slice);
                end
            end
            // step on only if the next process has already arrived
            if (slot + 1 >= proc_count)
                scan = 0;
            else if (arrival_tbl[slot + 1] <= now)
                scan = slot + 1;
            else
                scan = 0;
        end
        proc_count = 0;
        open_count = 0;
    endtask

    // Store one process word; the final one runs the schedule
    task automatic load_process(input logic [DATA_W-1:0] arr_in,
                                input logic [DATA_W-1:0] burst,
                                input logic              final_word);
        logic [DATA_W-1:0] arr;
        arr = arr_in;
        if (proc_count < TABLE_DEPTH) begin
            // arrivals never go backwards
            if (proc_count > 0 && arr < arrival_tbl[proc_count - 1])
                arr = arrival_tbl[proc_count - 1];
            arrival_tbl[proc_count]   = arr;
            burst_tbl[proc_count]     = burst;
            remaining_tbl[proc_count] = burst;
            finished[proc_count]      = 1'b0;
            proc_count++;
            open_count++;
        end
        if (final_word) replay_schedule();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Sample all three channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_completion exp_c;
        if (!i_rst_n) begin
            quantum    = QUANTUM_RESET;
            proc_count = 0;
            open_count = 0;
            completion_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                quantum = i_cfg_quantum;
            if (i_out_valid && !i_out_stall) begin
                if (completion_q.size() == 0) begin
                    $display("%0t: result word with none expected, index %0d",
                             $time, i_process_index);
                    mismatch_count++;
                end else begin
                    exp_c = completion_q.pop_front();
                    check_field("process_index", exp_c.index, i_process_index);
                    check_field("turnaround", exp_c.turnaround, i_turnaround);
                    check_field("waiting", exp_c.waiting, i_waiting);
                    check_field("total_waiting", exp_c.total_waiting, i_total_waiting);
                    check_field("total_turnaround", exp_c.total_turnaround,
                                i_total_turnaround);
                    check_field("last_result", exp_c.last, i_last_result);
                end
            end
            if (i_in_valid && !i_in_stall)
                load_process(i_arrival_time, i_burst_time, i_last_process);
        end
        pending_count = completion_q.size();
    end

endmodule

// ===== tb/round_robin_schedule_sim_unit_tb.sv =====
// ============================================================================
// round_robin_schedule_sim_unit_tb
// Drives process batches and quantum settings into the round-robin schedule
// unit with random gaps and output stalls; the monitor predicts and checks
// every completion word, and this top gives the verdict.
// ============================================================================
module round_robin_schedule_sim_unit_tb;
    import rrs_pkg::*;

    localparam int ITEM_TARGET  = 250;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 32;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_valid    = 1'b0;
    logic [Q_W-1:0]    i_cfg_quantum  = '0;
    logic              i_in_valid     = 1'b0;
    logic [DATA_W-1:0] i_arrival_time = '0;
    logic [DATA_W-1:0] i_burst_time   = '0;
    logic              i_last_process = 1'b0;
    logic              i_out_stall    = 1'b0;

    logic              o_cfg_ready;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [IDX_W-1:0]  o_process_index;
    logic [TIME_W-1:0] o_turnaround;
    logic [TIME_W-1:0] o_waiting;
    logic [SUM_W-1:0]  o_total_waiting;
    logic [SUM_W-1:0]  o_total_turnaround;
    logic              o_last_result;

    int          fail_count;
    int          pending;
    int unsigned cycle_count = 0;
    int          sent        = 0;
    bit          no_gaps     = 1'b0;
    int          stall_hold  = 0;
    int          stall_roll;

    always #5 i_clk = ~i_clk;

    round_robin_schedule_sim_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_quantum      (i_cfg_quantum),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_arrival_time     (i_arrival_time),
        .i_burst_time       (i_burst_time),
        .i_last_process     (i_last_process),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_process_index    (o_process_index),
        .o_turnaround       (o_turnaround),
        .o_waiting          (o_waiting),
        .o_total_waiting    (o_total_waiting),
        .o_total_turnaround (o_total_turnaround),
        .o_last_result      (o_last_result)
    );

    rrs_schedule_monitor u_monitor (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_quantum      (i_cfg_quantum),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_arrival_time     (i_arrival_time),
        .i_burst_time       (i_burst_time),
        .i_last_process     (i_last_process),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_process_index    (o_process_index),
        .i_turnaround       (o_turnaround),
        .i_waiting          (o_waiting),
        .i_total_waiting    (o_total_waiting),
        .i_total_turnaround (o_total_turnaround),
        .i_last_result      (o_last_result),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result backpressure: short and long stalls, with long free stretches
    always @(negedge i_clk) begin
        if (stall_hold == 0) begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 25) begin
                i_out_stall = 1'b1;
                stall_hold  = $urandom_range(1, 3);
            end else if (stall_roll < 30) begin
                i_out_stall = 1'b1;
                stall_hold  = $urandom_range(10, 40);
            end else if (stall_roll < 38) begin
                i_out_stall = 1'b0;
                stall_hold  = $urandom_range(50, 200);
            end else begin
                i_out_stall = 1'b0;
                stall_hold  = $urandom_range(1, 4);
            end
        end else begin
            stall_hold--;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one process word and hold it until taken
    task automatic send_process(input logic [DATA_W-1:0] arr,
                                input logic [DATA_W-1:0] burst,
                                input logic              final_word);
        int gap;
        i_in_valid     = 1'b1;
        i_arrival_time = arr;
        i_burst_time   = burst;
        i_last_process = final_word;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Hold off until every predicted word has come out, then let the unit settle
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_quantum(input logic [Q_W-1:0] q);
        wait_idle();
        i_cfg_valid   = 1'b1;
        i_cfg_quantum = q;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // One batch of random processes, sized to the current slice
    task automatic random_batch(input int count, input int slice);
        int unsigned arr;
        int unsigned burst;
        int          k;
        int          r;
        bit          big_ok;
        big_ok = (slice >= 200) && (count <= 3);
        arr    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 20);
        for (k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (k > 0) begin
                if (r < 10)      arr = $urandom_range(0, 65535);      // may go backwards
                else if (r < 20) arr = arr + $urandom_range(50, 2000); // idle gap in time
                else             arr = arr + $urandom_range(0, 2 * slice);
            end
            if (arr > 65535) arr = 65535;
            r = $urandom_range(0, 99);
            if (big_ok && r < 30) burst = $urandom_range(1, 65535);
            else if (r < 40)      burst = $urandom_range(1, slice);
            else                  burst = $urandom_range(1, 4 * slice);
            send_process(DATA_W'(arr), DATA_W'(burst), k == count - 1);
        end
    endtask

    initial begin : stimulus
        int batch_no;
        int slice;
        int size;
        int r;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        // reset quantum: ordinary batch with an out-of-order arrival
        send_process(16'd0, 16'd10, 1'b0);
        send_process(16'd3, 16'd25, 1'b0);
        send_process(16'd5, 16'd9, 1'b0);
        send_process(16'd2, 16'd4, 1'b1);
        // nothing ready at start, late arrivals, latest possible arrival
        send_process(16'd100, 16'd5, 1'b0);
        send_process(16'd500, 16'd30, 1'b0);
        send_process(16'hFFFF, 16'd1, 1'b1);
        // single process
        send_process(16'd7, 16'd3, 1'b1);
        // zero burst
        send_process(16'd4, 16'd0, 1'b0);
        send_process(16'd4, 16'd12, 1'b1);
        // widest slice with the longest bursts
        set_quantum(8'hFF);
        send_process(16'd0, 16'hFFFF, 1'b0);
        send_process(16'hFFFF, 16'hFFFF, 1'b1);
        // zero quantum behaves as one
        set_quantum(8'h00);
        send_process(16'd0, 16'd3, 1'b0);
        send_process(16'd1, 16'd0, 1'b0);
        send_process(16'd1, 16'd2, 1'b1);
        set_quantum(8'd1);
        send_process(16'd0, 16'd5, 1'b0);
        send_process(16'd2, 16'd3, 1'b1);
        slice = 1;

        // random batches; one overfills the table
        sent     = 0;
        batch_no = 0;
        while (sent < ITEM_TARGET) begin
            if (batch_no % 4 == 0) begin
                r = $urandom_range(0, 99);
                if (r < 15)      slice = 1;
                else if (r < 30) slice = 255;
                else             slice = $urandom_range(2, 254);
                set_quantum(Q_W'(slice));
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (batch_no == 5) size = $urandom_range(66, 70);
            else if (r < 10)   size = $urandom_range(13, 40);
            else               size = $urandom_range(1, 12);
            random_batch(size, slice);
            if (batch_no == 2) wait_idle();
            batch_no++;
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== round_robin_schedule_sim_unit.f =====
hdl/rrs_pkg.sv
hdl/rrs_seq.sv
hdl/rrs_datapath.sv
hdl/round_robin_schedule_sim_unit.sv
tb/rrs_schedule_monitor.sv
tb/round_robin_schedule_sim_unit_tb.sv
